// ===== rtl/core/pir_pkg.sv =====
package pir_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    // apb register map, one word register at byte 0
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] ADDR_COLOR_COUNT = 3'd0;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] color_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pir_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_index;
        logic       was_remapped;
    } pir_out_t;

    typedef struct packed {
        logic        we;
        logic [7:0]  addr;
        logic [23:0] rgb;
    } pir_pal_wr_t;

endpackage

// ===== rtl/core/pir_palette.sv =====
module pir_palette #(
    parameter int ENTRIES = pir_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  pir_pkg::pir_pal_wr_t wr,
    input  logic [7:0]           rd_addr,
    input  logic [23:0]          key,
    output logic                 match
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [23:0] mem [ENTRIES];
    logic [23:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr[AW-1:0]] <= wr.rgb;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    // exact colour compare against the entry read last cycle
    assign match = (rd_data_reg == key);

endmodule

// ===== rtl/core/palette_index_remapper.sv =====
// steps: load, clear and unused commands end in the execute state; in-range pixels go to
// output, cache hits via the cross-reference read, misses via any scan and the cache fill
// throughput: one item at a time, held back by the palette scan and output back-pressure
// reset: synchronous active-low aresetn clears the sequencer, output valid, colour
// count and all cache valid bits at once; palette and cache targets are not cleared
module palette_index_remapper #(
    parameter int PALETTE_ENTRIES = pir_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pir_pkg::CFG_AW-1:0] paddr,
    input  logic [pir_pkg::CFG_DW-1:0] pwdata,
    output logic [pir_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pir_pkg::pir_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output pir_pkg::pir_out_t          m_data
);

    localparam logic [8:0] ENTRIES_W = 9'(PALETTE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_XREF,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FILL,
        ST_OUT
    } state_t;

    state_t               state_reg;
    pir_pkg::pir_in_t     in_reg;
    pir_pkg::pir_out_t    m_data_reg;
    logic                 m_valid_reg;
    logic [7:0]           color_count_reg;
    logic [7:0]           scan_reg;
    logic [7:0]           limit_reg;
    logic [7:0]           res_index_reg;
    logic                 res_remap_reg;
    logic [255:0]         xref_valid_reg;
    logic [7:0]           xref_mem [256];
    logic [7:0]           xref_q_reg;

    logic                 cfg_wr;
    logic                 in_range;
    logic [7:0]           limit_next;
    logic                 pal_match;
    pir_pkg::pir_pal_wr_t pal_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr == pir_pkg::ADDR_COLOR_COUNT);
    assign prdata  = (paddr == pir_pkg::ADDR_COLOR_COUNT) ?
                     {{(pir_pkg::CFG_DW-8){1'b0}}, color_count_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_count_reg <= '0;
        end else if (cfg_wr) begin
            color_count_reg <= pwdata[7:0];
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign in_range = (in_reg.color_index < color_count_reg);
    // scan covers min(count, entries); count never exceeds 255
    assign limit_next = ({1'b0, color_count_reg} < ENTRIES_W) ? color_count_reg
                                                               : 8'(PALETTE_ENTRIES);

    always_comb begin
        pal_wr.we   = (state_reg == ST_EXEC) && (in_reg.command == pir_pkg::CMD_LOAD) &&
                      ({1'b0, in_reg.color_index} < ENTRIES_W);
        pal_wr.addr = in_reg.color_index;
        pal_wr.rgb  = {in_reg.red, in_reg.green, in_reg.blue};
    end

    pir_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd_addr (scan_reg),
        .key     ({in_reg.red, in_reg.green, in_reg.blue}),
        .match   (pal_match)
    );

    // cross-reference targets, written when a scan result is cached
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FILL) begin
            xref_mem[in_reg.color_index] <= res_index_reg;
        end
        xref_q_reg <= xref_mem[in_reg.color_index];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            xref_valid_reg <= '0;
        end else begin
            // the output state reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (in_reg.command)
                        pir_pkg::CMD_LOAD: begin
                            state_reg <= ST_IDLE;
                        end
                        pir_pkg::CMD_CLEAR: begin
                            xref_valid_reg <= '0;
                            state_reg      <= ST_IDLE;
                        end
                        pir_pkg::CMD_PIXEL: begin
                            res_remap_reg <= !in_range;
                            scan_reg      <= '0;
                            limit_reg     <= limit_next;
                            if (in_range) begin
                                res_index_reg <= in_reg.color_index;
                                state_reg     <= ST_OUT;
                            end else if (xref_valid_reg[in_reg.color_index]) begin
                                state_reg <= ST_XREF;
                            end else if (limit_next == 8'd0) begin
                                res_index_reg <= '0;
                                state_reg     <= ST_FILL;
                            end else begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_XREF: begin
                    res_index_reg <= xref_q_reg;
                    state_reg     <= ST_OUT;
                end
                ST_SCAN_RD: begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP: begin
                    if (pal_match) begin
                        res_index_reg <= scan_reg;
                        state_reg     <= ST_FILL;
                    end else if (scan_reg + 8'd1 == limit_reg) begin
                        // no exact match, fall back to entry zero
                        res_index_reg <= '0;
                        state_reg     <= ST_FILL;
                    end else begin
                        scan_reg  <= scan_reg + 8'd1;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_FILL: begin
                    xref_valid_reg[in_reg.color_index] <= 1'b1;
                    state_reg                          <= ST_OUT;
                end
                ST_OUT: begin
                    // hold the result until the output register frees up
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.out_red      <= in_reg.red;
                        m_data_reg.out_green    <= in_reg.green;
                        m_data_reg.out_blue     <= in_reg.blue;
                        m_data_reg.out_index    <= res_index_reg;
                        m_data_reg.was_remapped <= res_remap_reg;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_remap_in_palette: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.was_remapped |-> ({1'b0, m_data.out_index} < ENTRIES_W))
        else $error("remapped index beyond palette");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN_CMP |-> scan_reg < limit_reg)
        else $error("scan pointer past limit");

    a_fill_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILL |=> xref_valid_reg[in_reg.color_index])
        else $error("cached entry not marked valid");
`endif

endmodule
